FILE: rtl/dwq_pkg.sv
package dwq_pkg;

  localparam int unsigned ID_W       = 10;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_GET = 1'b1
  } op_e;

  // One request as held in the input register.
  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] id;
    logic            is_input;
  } req_t;

  // One result; add_accepted sits in the lowest bit.
  typedef struct packed {
    logic [ID_W-1:0] item_out;
    logic            item_valid;
    logic            add_accepted;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

endpackage

FILE: rtl/dwq_mark_ram.sv
module dwq_mark_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  output logic          rd_data_o
);

  logic mem [DEPTH];
  logic rd_q;

  // Read returns the value as it stands after a write at the same edge.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      if (we_i && (waddr_i == rd_addr_i)) begin
        rd_q <= wdata_i;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: rtl/dwq_id_fifo.sv
module dwq_id_fifo
  import dwq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned CW    = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fifo_ctrl_t      ctrl_i,
  input  logic [ID_W-1:0] push_id_i,
  output logic [ID_W-1:0] head_id_o,
  output logic            empty_o
);

  logic [ID_W-1:0] mem [DEPTH];
  logic [ID_W-1:0] rd_q;
  logic [AW-1:0]   head_q, head_d;
  logic [AW-1:0]   tail_q, tail_d;
  logic [CW-1:0]   count_q, count_d;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] pos);
    logic [AW-1:0] nxt;
    if (pos == AW'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = pos + 1'b1;
    end
    return nxt;
  endfunction

  always_comb begin
    head_d  = ctrl_i.pop  ? next_slot(head_q) : head_q;
    tail_d  = ctrl_i.push ? next_slot(tail_q) : tail_q;
    count_d = count_q;
    case ({ctrl_i.push, ctrl_i.pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Keep the entry at the next head in the read register, bypassing a push
  // that lands there in the same cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= push_id_i;
    end
    if (ctrl_i.push && (tail_q == head_d)) begin
      rd_q <= push_id_i;
    end else begin
      rd_q <= mem[head_d];
    end
  end

  assign head_id_o = rd_q;
  assign empty_o   = (count_q == '0);

endmodule

FILE: rtl/dedup_work_queue_with_idle_slot.sv
// Channel     Direction  Transfer when            Payload
// s_axis      in         tvalid & tready          tuser: operation; tdata: item_id, is_input_item
// m_axis      out        tvalid & tready          tdata: add_accepted, item_valid, item_out
// cfg         in         cfg_we_i                 cfg_wdata_i: idle_period
//
// One request per cycle is sustained while results are taken and no clearing pass
// runs. The input register loads at the input transfer edge and the result register
// at the edge that processes the held request, which waits while a result stalls.
// After reset a clearing pass sweeps all min(ITEM_COUNT, 1024) entries (1024 by
// default) of the queued-mark memory, one entry a cycle; s_axis_tready stays low.
// A stalled result holds in the result register while one more request waits
// in the input register; then s_axis_tready drops.
module dedup_work_queue_with_idle_slot
  import dwq_pkg::*;
#(
  parameter int unsigned ITEM_COUNT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [9:0] item_id, [10] is_input_item, rest 0
  input  logic                  s_axis_tuser,   // [0] operation
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] add_accepted, [1] item_valid,
                                                // [11:2] item_out, rest 0
  input  logic                  cfg_we_i,
  input  logic [PERIOD_W-1:0]   cfg_wdata_i
);

  // Ids are ID_W bits wide, so no more than 1 << ID_W distinct ids can ever be queued.
  localparam int unsigned ID_SPACE = 1 << ID_W;
  localparam int unsigned DEPTH    = (ITEM_COUNT < ID_SPACE) ? ITEM_COUNT : ID_SPACE;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned CW       = $clog2(DEPTH + 1);

  // Clearing pass
  logic          clearing_q, clearing_d;
  logic [AW-1:0] clr_idx_q, clr_idx_d;

  // Input register
  logic in_valid_q, in_valid_d;
  req_t req_q, req_in;

  // Result register
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  // Config and get counter
  logic [PERIOD_W-1:0] idle_period_q;
  logic [PERIOD_W-1:0] get_cnt_q, get_cnt_d, get_cnt_inc;

  logic            accept, proc;
  logic            mark_rd;
  logic            in_range, add_ok, get_pop;
  logic [ID_W-1:0] head_id;
  logic            fifo_empty;
  fifo_ctrl_t      fifo_ctrl;

  logic          mark_we, mark_wdata;
  logic [AW-1:0] mark_waddr;

  // Handshake: process the held request whenever the result register is free
  // or being drained this cycle.
  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !clearing_q && (!in_valid_q || proc);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign req_in.op       = op_e'(s_axis_tuser);
  assign req_in.id       = s_axis_tdata[ID_W-1:0];
  assign req_in.is_input = s_axis_tdata[ID_W];

  // Decide the request held in the input register.
  assign in_range    = (32'(req_q.id) < ITEM_COUNT);
  assign get_cnt_inc = get_cnt_q + 1'b1;

  always_comb begin
    add_ok    = 1'b0;
    get_pop   = 1'b0;
    get_cnt_d = get_cnt_q;
    unique case (req_q.op)
      OP_ADD: begin
        add_ok = in_range && !req_q.is_input && !mark_rd;
      end
      OP_GET: begin
        if (get_cnt_inc == idle_period_q) begin
          // forced idle slot: return nothing, queue untouched
          get_cnt_d = '0;
        end else begin
          get_cnt_d = get_cnt_inc;
          get_pop   = !fifo_empty;
        end
      end
    endcase
  end

  assign fifo_ctrl.push = proc && add_ok;
  assign fifo_ctrl.pop  = proc && get_pop;

  // Mark write port: clearing pass, set on push, clear on pop.
  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = '0;
    mark_wdata = 1'b0;
    if (clearing_q) begin
      mark_we    = 1'b1;
      mark_waddr = clr_idx_q;
    end else if (fifo_ctrl.push) begin
      mark_we    = 1'b1;
      mark_waddr = req_q.id[AW-1:0];
      mark_wdata = 1'b1;
    end else if (fifo_ctrl.pop) begin
      mark_we    = 1'b1;
      mark_waddr = head_id[AW-1:0];
    end
  end

  always_comb begin
    clearing_d = clearing_q;
    clr_idx_d  = clr_idx_q;
    if (clearing_q) begin
      if (clr_idx_q == AW'(DEPTH - 1)) begin
        clearing_d = 1'b0;
      end else begin
        clr_idx_d = clr_idx_q + 1'b1;
      end
    end
  end

  // Advance the two register stages.
  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (proc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    out_d.add_accepted = add_ok;
    out_d.item_valid   = get_pop;
    out_d.item_out     = get_pop ? head_id : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q    <= 1'b1;
      clr_idx_q     <= '0;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      get_cnt_q     <= '0;
      idle_period_q <= '0;
    end else begin
      clearing_q  <= clearing_d;
      clr_idx_q   <= clr_idx_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (proc && (req_q.op == OP_GET)) begin
        get_cnt_q <= get_cnt_d;
      end
      if (cfg_we_i) begin
        idle_period_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_in;
    end
    if (proc) begin
      out_q <= out_d;
    end
  end

  dwq_mark_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mark_ram (
    .clk_i    (clk_i),
    .rd_en_i  (accept),
    .rd_addr_i(req_in.id[AW-1:0]),
    .we_i     (mark_we),
    .waddr_i  (mark_waddr),
    .wdata_i  (mark_wdata),
    .rd_data_o(mark_rd)
  );

  dwq_id_fifo #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_id_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (fifo_ctrl),
    .push_id_i(req_q.id),
    .head_id_o(head_id),
    .empty_o  (fifo_empty)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), out_q};

endmodule

FILE: tb/sv/tb_dedup_work_queue_with_idle_slot.sv
`timescale 1ns / 100ps

module tb_dedup_work_queue_with_idle_slot;
  import dwq_pkg::*;

  localparam int unsigned ITEMS       = 1024;
  localparam int unsigned FILL        = 256;   // distinct ids queued in the fill phase
  localparam int unsigned HOLD_CYCLES = 300;   // long output hold that backs up the input
  localparam int unsigned SETTLE      = 4;     // input register + result register + margin
  localparam int unsigned QUIET_LIMIT = 5000;  // covers the mark-clearing sweep after reset

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;    // [9:0] item_id, [10] is_input_item
  logic                  s_axis_tuser  = 1'b0;  // [0] operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;          // [0] add_accepted, [1] item_valid,
                                                // [11:2] item_out
  logic                  cfg_we_i      = 1'b0;
  logic [PERIOD_W-1:0]   cfg_wdata_i   = '0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  dedup_work_queue_with_idle_slot #(
    .ITEM_COUNT(ITEMS)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Queue model: mirrors the mark table, the id order, the get counter and
  // the idle-period register.
  // ---------------------------------------------------------------------------
  logic [PERIOD_W-1:0] idle_period_q = '0;
  logic [PERIOD_W-1:0] get_count     = '0;
  bit                  marked [ITEMS];
  logic [ID_W-1:0]     id_order [$];
  result_t             due_results [$];

  int errors        = 0;
  int n_requests    = 0;
  int n_added       = 0;
  int n_popped      = 0;
  int n_forced_idle = 0;
  int deepest       = 0;
  int n_period_sets = 0;
  int n_backed_up   = 0;

  // Apply one request to the model and return the result it must produce.
  function automatic result_t serve_request(req_t r);
    result_t res;
    res = '0;
    n_requests++;
    if (r.op == OP_ADD) begin
      // Refuse ids past the item count, input items and ids already waiting;
      // the size test never fires while the marks keep each id queued once.
      if ((32'(r.id) < ITEMS) && !r.is_input && !marked[r.id] &&
          id_order.size() < ITEMS) begin
        marked[r.id] = 1'b1;
        id_order.push_back(r.id);
        res.add_accepted = 1'b1;
        n_added++;
        if (id_order.size() > deepest) deepest = id_order.size();
      end
      return res;
    end
    // Every get bumps the 16-bit counter first, wrapping at 65535.
    get_count = get_count + 1'b1;
    if (get_count == idle_period_q) begin
      // Forced idle slot: pop nothing, even if ids are waiting.
      get_count = '0;
      n_forced_idle++;
      return res;
    end
    if (id_order.size() > 0) begin
      res.item_out   = id_order.pop_front();
      res.item_valid = 1'b1;
      marked[res.item_out] = 1'b0;
      n_popped++;
    end
    return res;
  endfunction

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Compare one output transfer against the oldest waiting result.
  task automatic check_result(logic [OUT_DATA_W-1:0] word);
    result_t got;
    result_t want;
    got = result_t'(word[$bits(result_t)-1:0]);
    if (due_results.size() == 0) begin
      $error("result 0x%0h arrived with no request outstanding", word);
      errors++;
      return;
    end
    want = due_results.pop_front();
    compare_field("add_accepted", 16'(want.add_accepted), 16'(got.add_accepted));
    compare_field("item_valid", 16'(want.item_valid), 16'(got.item_valid));
    compare_field("item_out", 16'(want.item_out), 16'(got.item_out));
    compare_field("tdata padding", '0, 16'(word[OUT_DATA_W-1:$bits(result_t)]));
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels and the register write at the rising edge.
  // Check the output before booking the new request so that a result showing
  // up too early counts as unexpected.
  // ---------------------------------------------------------------------------
  req_t cur_req;
  logic in_xfer = 1'b0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= s_axis_tvalid && s_axis_tready;
      if (cfg_we_i) idle_period_q = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) due_results.push_back(serve_request(cur_req));
      if (s_axis_tvalid && !s_axis_tready && !m_axis_tready) n_backed_up++;
    end
  end

  // ---------------------------------------------------------------------------
  // Idle pattern: mostly single-cycle gaps, some longer ones, a few very long ones.
  // ---------------------------------------------------------------------------
  int tx_gap_pct   = 30;   // chance of a gap after an input transfer
  int rx_stall_pct = 20;   // chance of starting an output stall

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 1;
    if (roll < 95) return $urandom_range(2, 5);
    return $urandom_range(12, 48);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued requests at the falling edge; hold an offered
  // request until the rising edge that takes it.
  // ---------------------------------------------------------------------------
  req_t pending_reqs [$];
  req_t next_req;
  int   gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= 0;
    end else if (s_axis_tvalid && !in_xfer) begin
      // hold: the offer is still waiting for tready
    end else if (gap_left > 0) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= gap_left - 1;
    end else if (pending_reqs.size() > 0) begin
      next_req = pending_reqs.pop_front();
      cur_req       <= next_req;
      s_axis_tdata  <= IN_DATA_W'({next_req.is_input, next_req.id});
      s_axis_tuser  <= next_req.op;
      s_axis_tvalid <= 1'b1;
      gap_left      <= ($urandom_range(0, 99) < tx_gap_pct) ? pick_gap() : 0;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus long holds on request from the sequence.
  // ---------------------------------------------------------------------------
  int stall_left   = 0;
  int hold_left    = 0;
  int holds_asked  = 0;
  int holds_served = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      hold_left     <= 0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_served < holds_asked) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES - 1;
      holds_served  <= holds_served + 1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      m_axis_tready <= 1'b0;
      stall_left    <= pick_gap() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no transfer happens on either side for too long.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, due_results.size());
      $display("tb_dedup_work_queue_with_idle_slot: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  task automatic offer(op_e op, int id, bit is_input);
    req_t r;
    r.op       = op;
    r.id       = id[ID_W-1:0];
    r.is_input = is_input;
    pending_reqs.push_back(r);
  endtask

  // Block until every queued request has transferred and every result is back,
  // then let the pipeline settle.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_period(logic [PERIOD_W-1:0] value);
    wait_drained();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk);
    cfg_we_i    <= 1'b0;
    n_period_sets++;
  endtask

  // Random mix; half the ids come from a small pool so duplicates are common.
  task automatic random_requests(int count, int get_pct);
    logic [ID_W-1:0] pool [8];
    int              id;
    foreach (pool[i]) pool[i] = $urandom_range(0, ITEMS - 1);
    repeat (count) begin
      id = $urandom_range(0, 1) ? pool[$urandom_range(0, 7)] : $urandom_range(0, ITEMS - 1);
      offer(($urandom_range(0, 99) < get_pct) ? OP_GET : OP_ADD, id,
            $urandom_range(0, 99) < 15);
    end
  endtask

  // Queue FILL distinct ids in random order so the queue runs deep, knock on
  // it with duplicates, then drain it with gets.
  task automatic fill_and_drain();
    int order [ITEMS];
    int j;
    int tmp;
    foreach (order[i]) order[i] = i;
    for (int i = ITEMS - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < FILL; i++) offer(OP_ADD, order[i], 1'b0);
    repeat (24) offer(OP_ADD, order[$urandom_range(0, FILL - 1)], 1'b0);
    repeat (FILL + FILL / 5 + 16) offer(OP_GET, $urandom_range(0, ITEMS - 1), 1'b0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, idle slot every third get. These wait out the clearing
    // sweep in the driver.
    set_period(16'd3);
    offer(OP_ADD, 0, 1'b0);          // lowest id
    offer(OP_ADD, 1023, 1'b0);       // highest id
    offer(OP_ADD, 1023, 1'b0);       // duplicate: refuse
    offer(OP_ADD, 5, 1'b1);          // input item: refuse
    offer(OP_ADD, 682, 1'b1);        // input item, alternating bits
    offer(OP_ADD, 341, 1'b0);
    offer(OP_GET, 1023, 1'b1);       // pop 0; id and flag ignored on a get
    offer(OP_GET, 0, 1'b0);          // pop 1023
    offer(OP_GET, 0, 1'b0);          // forced idle while 341 still waits
    offer(OP_ADD, 341, 1'b0);        // still queued: refuse
    offer(OP_GET, 682, 1'b0);        // pop 341
    offer(OP_ADD, 341, 1'b0);        // queued again after its pop
    offer(OP_ADD, 0, 1'b0);
    offer(OP_GET, 0, 1'b0);          // pop 341
    offer(OP_GET, 0, 1'b0);          // forced idle
    offer(OP_GET, 0, 1'b0);          // pop 0
    offer(OP_GET, 0, 1'b0);          // empty queue
    offer(OP_GET, 0, 1'b0);          // forced idle on an empty queue
    offer(OP_ADD, 682, 1'b0);
    offer(OP_GET, 0, 1'b1);          // pop 682

    // Period one: the get counter already stands past zero, so no get here is forced idle; duplicates get refused.
    set_period(16'd1);
    random_requests(150, 40);

    // Long output hold with the sender pushing back-to-back.
    set_period(16'd2);
    tx_gap_pct = 0;
    holds_asked++;
    random_requests(250, 45);

    // Largest period, no idling on either side.
    set_period(16'hFFFF);
    rx_stall_pct = 0;
    random_requests(200, 45);

    tx_gap_pct   = 30;
    rx_stall_pct = 20;
    set_period(16'd7);
    fill_and_drain();

    set_period(PERIOD_W'($urandom_range(3, 40)));
    random_requests(150, 50);

    // Period zero: the counter does not wrap within this run, so no get is
    // forced idle.
    set_period(16'd0);
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    random_requests(150, 60);

    set_period(PERIOD_W'($urandom_range(4, 12)));
    tx_gap_pct   = 30;
    rx_stall_pct = 20;
    random_requests(150, 50);

    wait_drained();
    repeat (2 * SETTLE) @(negedge clk);

    $display("ran %0d requests: %0d adds queued, %0d ids popped, %0d forced idle slots",
             n_requests, n_added, n_popped, n_forced_idle);
    $display("%0d idle-period settings, deepest queue %0d, %0d input cycles backed up",
             n_period_sets, deepest, n_backed_up);
    if (errors == 0) begin
      $display("tb_dedup_work_queue_with_idle_slot: PASS");
    end else begin
      $display("tb_dedup_work_queue_with_idle_slot: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dwq_pkg.sv
rtl/dwq_mark_ram.sv
rtl/dwq_id_fifo.sv
rtl/dedup_work_queue_with_idle_slot.sv
tb/sv/tb_dedup_work_queue_with_idle_slot.sv
